@@ hdl/esc_pkg.sv @@
// Shared types, constants and helpers for the environmental sensor compensation core.
`timescale 1ns / 1ps
package esc_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_TEMP    = 3'd0;
   localparam logic [2:0] CSR_PRESS_A = 3'd1;
   localparam logic [2:0] CSR_PRESS_B = 3'd2;
   localparam logic [2:0] CSR_PRESS_C = 3'd3;
   localparam logic [2:0] CSR_HUM_A   = 3'd4;
   localparam logic [2:0] CSR_HUM_B   = 3'd5;

   // Pipeline shape
   localparam int PRE_STAGES  = 12;
   localparam int DIV_STAGES  = 64;
   localparam int POST_STAGES = 6;
   localparam int NSTG        = PRE_STAGES + DIV_STAGES + POST_STAGES;

   // Compensation constants
   localparam logic signed [32:0] T_OFS      = 33'sd128000;
   localparam logic        [20:0] P_BASE     = 21'd1048576;
   localparam logic        [11:0] P_SCALE    = 12'd3125;
   localparam logic signed [31:0] H_OFS      = 32'sd76800;
   localparam logic signed [31:0] H_RND      = 32'sd16384;
   localparam logic signed [31:0] H_D_OFS    = 32'sd32768;
   localparam logic signed [31:0] H_E_OFS    = 32'sd2097152;
   localparam logic signed [31:0] H_F_RND    = 32'sd8192;
   localparam logic signed [31:0] HUM_CLAMP  = 32'sd419430400;
   localparam logic        [63:0] P_V1_BIAS  = 64'h0000_8000_0000_0000;

   typedef struct packed {
      logic signed [31:0] temp;
      logic signed [31:0] tf;
   } side_type;

   typedef struct packed {
      logic [30:0]  rem;
      logic [63:0]  nq;     // dividend bits shift out on top, quotient bits shift in below
      logic [30:0]  dmag;
      logic         neg;
      logic         inv;
      side_type     side;
      logic [31:0]  hx_a;
      logic [31:0]  hx_b;
   } div_type;

   typedef struct packed {
      side_type     side;
      logic [16:0]  hum;
      logic         inv;
   } post_type;

   // Final humidity correction, clamp and scale down to Q7.10
   function automatic logic [16:0] hum_fin(input logic signed [31:0] xa,
                                           input logic signed [31:0] hm);
      logic signed [31:0] x2;
      x2 = xa - (hm >>> 4);
      if (x2 < 0)
         x2 = '0;
      else if (x2 > HUM_CLAMP)
         x2 = HUM_CLAMP;
      return x2[28:12];
   endfunction

endpackage

@@ hdl/env_sensor_compensation_core.sv @@
// Environmental sensor compensation core: fully pipelined integer datasheet compensation.
// Throughput: one sample triple per cycle while the result is not stalled; the 64-stage
// restoring divider for pressure sets the depth, one quotient bit per stage.
// A stalled result freezes the whole pipeline; bubbles travel as cleared valid bits.
// Synchronous reset clears all valid bits and the coefficient registers.
`timescale 1ns / 1ps
module env_sensor_compensation_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [19:0]        req_raw_temperature,
   input  logic [19:0]        req_raw_pressure,
   input  logic [15:0]        req_raw_humidity,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_temperature,
   output logic signed [31:0] rsp_fine_temperature,
   output logic [31:0]        rsp_pressure,
   output logic               rsp_pressure_invalid,
   output logic [16:0]        rsp_humidity,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_wdata
);

   localparam int NS = esc_pkg::NSTG;
   localparam int ND = esc_pkg::DIV_STAGES;
   localparam int POST_OFS = esc_pkg::POST_STAGES + 1;

   logic [47:0] temp_coeffs_ff, press_a_ff, press_b_ff, press_c_ff;
   logic [31:0] hum_a_ff, hum_b_ff;

   logic [15:0]        t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
   logic [7:0]         h1, h3;
   logic signed [11:0] h4, h5;
   logic signed [7:0]  h6;

   logic              en;
   logic [NS-1:0]     vld_ff;

   // stage registers
   logic [19:0]        rt_ff;
   logic [19:0]        rp_ff [1:8];
   logic [15:0]        rh_ff [1:6];
   logic signed [31:0] ma_ff, ma_in, mb_ff, mb_in;
   logic signed [31:0] v1t_ff, v1t_in, v2t_ff, v2t_in;
   logic signed [31:0] tf_ff, tf_in;
   esc_pkg::side_type  side_ff [5:11];
   esc_pkg::side_type  side_in;
   logic signed [32:0] v1p_ff, v1p_in;
   logic signed [31:0] xh_ff, xh_in;
   logic [63:0]        v1sq_ff, v1sq_in;
   logic signed [48:0] pm5_ff, pm5_in, pm2_ff, pm2_in;
   logic signed [31:0] h5x_ff, h5x_in, xh6_ff, xh6_in, xh3_ff, xh3_in;
   logic signed [48:0] q6lo_ff, q6lo_in, q3lo_ff, q3lo_in, pm5b_ff, pm2b_ff;
   logic [31:0]        q6hi_ff, q6hi_in, q3hi_ff, q3hi_in;
   logic signed [31:0] ah_ff [7:10];
   logic signed [31:0] ah_in, ch_ff, ch_in, dh_ff, dh_in;
   logic [63:0]        v2_ff, v2_in, v1b_ff, v1b_in;
   logic signed [31:0] cd_ff, cd_in;
   logic [63:0]        x1_ff, x1_in, nv_ff, nv_in;
   logic signed [31:0] eh_ff, eh_in;
   logic signed [49:0] xlo_ff, xlo_in;
   logic [31:0]        xhi_ff, xhi_in, nhi_ff, nhi_in;
   logic [43:0]        nlo_ff, nlo_in;
   logic signed [31:0] fh_ff, fh_in;
   logic signed [30:0] den_ff, den_in;
   logic [63:0]        num_ff, num_in;
   logic signed [31:0] xa_ff, xa_in;
   esc_pkg::div_type   div_ff [0:ND];
   esc_pkg::div_type   div_in [0:ND];
   logic [63:0]        qs_ff [0:4];
   logic [63:0]        qs_in;
   esc_pkg::post_type  pst_ff [0:4];
   esc_pkg::post_type  pst_in;
   logic [63:0]        sslo_ff, sslo_in;
   logic [31:0]        sshi_ff, sshi_in, b8hi_ff, b8hi_in, a9hi_ff, a9hi_in;
   logic signed [48:0] b8lo_ff, b8lo_in, a9lo_ff, a9lo_in;
   logic [63:0]        ss_ff, ss_in;
   logic [63:0]        b8_ff [0:2];
   logic [63:0]        b8_in, a9_ff, a9_in;
   logic signed [31:0] temp_o_ff, tf_o_ff;
   logic [31:0]        pres_o_ff, pres_in;
   logic               inv_o_ff;
   logic [16:0]        hum_o_ff;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_a_ff     <= '0;
         press_b_ff     <= '0;
         press_c_ff     <= '0;
         hum_a_ff       <= '0;
         hum_b_ff       <= '0;
      end else if (csr_we) begin
         case (csr_index)
            esc_pkg::CSR_TEMP:    temp_coeffs_ff <= csr_wdata;
            esc_pkg::CSR_PRESS_A: press_a_ff     <= csr_wdata;
            esc_pkg::CSR_PRESS_B: press_b_ff     <= csr_wdata;
            esc_pkg::CSR_PRESS_C: press_c_ff     <= csr_wdata;
            esc_pkg::CSR_HUM_A:   hum_a_ff       <= csr_wdata[31:0];
            esc_pkg::CSR_HUM_B:   hum_b_ff       <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   assign t1 = temp_coeffs_ff[15:0];
   assign t2 = temp_coeffs_ff[31:16];
   assign t3 = temp_coeffs_ff[47:32];
   assign p1 = press_a_ff[15:0];
   assign p2 = press_a_ff[31:16];
   assign p3 = press_a_ff[47:32];
   assign p4 = press_b_ff[15:0];
   assign p5 = press_b_ff[31:16];
   assign p6 = press_b_ff[47:32];
   assign p7 = press_c_ff[15:0];
   assign p8 = press_c_ff[31:16];
   assign p9 = press_c_ff[47:32];
   assign h1 = hum_a_ff[7:0];
   assign h2 = hum_a_ff[23:8];
   assign h3 = hum_a_ff[31:24];
   assign h4 = hum_b_ff[11:0];
   assign h5 = hum_b_ff[23:12];
   assign h6 = hum_b_ff[31:24];

   // ---------------- flow control ----------------
   assign en        = !(vld_ff[NS-1] && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (en)
         vld_ff <= {vld_ff[NS-2:0], req_valid};
   end

   // ---------------- stages 2 to 11 ----------------
   always_comb begin
      logic signed [18:0] ta;
      logic signed [17:0] tb;
      logic signed [34:0] pa;
      logic signed [35:0] pb;
      logic signed [47:0] pc;
      logic signed [31:0] t5;
      logic signed [65:0] sq66;
      logic signed [43:0] p44;
      logic signed [39:0] p40;
      logic signed [40:0] p41;
      logic [31:0]        g32;
      logic [63:0]        u64;
      logic signed [63:0] cd64;
      logic [20:0]        pd21;
      logic signed [47:0] e48;
      logic [31:0]        f32;
      logic [63:0]        u64b;
      logic signed [63:0] x64;

      // temperature
      ta    = $signed({2'b00, rt_ff[19:3]}) - $signed({2'b00, t1, 1'b0});
      tb    = $signed({2'b00, rt_ff[19:4]}) - $signed({2'b00, t1});
      pa    = ta * t2;
      pb    = tb * tb;
      ma_in = pa[31:0];
      mb_in = pb[31:0];

      v1t_in = ma_ff >>> 11;
      pc     = (mb_ff >>> 12) * t3;
      v2t_in = $signed(pc[31:0]) >>> 14;

      tf_in = v1t_ff + v2t_ff;

      t5           = tf_ff * 32'sd5 + 32'sd128;
      side_in.temp = t5 >>> 8;
      side_in.tf   = tf_ff;
      v1p_in       = 33'(tf_ff) - esc_pkg::T_OFS;
      xh_in        = tf_ff - esc_pkg::H_OFS;

      // products of the offset fine temperature
      sq66    = v1p_ff * v1p_ff;
      v1sq_in = sq66[63:0];
      pm5_in  = v1p_ff * p5;
      pm2_in  = v1p_ff * p2;
      p44     = xh_ff * h5;
      h5x_in  = p44[31:0];
      p40     = xh_ff * h6;
      xh6_in  = p40[31:0];
      p41     = xh_ff * $signed({1'b0, h3});
      xh3_in  = p41[31:0];

      // 64 x 16 products split in halves, summed next stage
      q6lo_in = $signed({1'b0, v1sq_ff[31:0]}) * p6;
      q6hi_in = v1sq_ff[63:32] * {{16{p6[15]}}, p6};
      q3lo_in = $signed({1'b0, v1sq_ff[31:0]}) * p3;
      q3hi_in = v1sq_ff[63:32] * {{16{p3[15]}}, p3};
      g32     = {2'b00, rh_ff[6], 14'd0} - {h4, 20'd0} - h5x_ff + esc_pkg::H_RND;
      ah_in   = $signed(g32) >>> 15;
      ch_in   = xh6_ff >>> 10;
      dh_in   = (xh3_ff >>> 11) + esc_pkg::H_D_OFS;

      v2_in  = 64'(q6lo_ff) + {q6hi_ff, 32'd0} + (64'(pm5b_ff) << 17) + (64'(p4) << 35);
      u64    = 64'(q3lo_ff) + {q3hi_ff, 32'd0};
      v1b_in = ($signed(u64) >>> 8) + (64'(pm2b_ff) << 12);
      cd64   = ch_ff * dh_ff;
      cd_in  = cd64[31:0];

      x1_in = esc_pkg::P_V1_BIAS + v1b_ff;
      pd21  = esc_pkg::P_BASE - {1'b0, rp_ff[8]};
      nv_in = ({43'd0, pd21} << 31) - v2_ff;
      eh_in = (cd_ff >>> 10) + esc_pkg::H_E_OFS;

      xlo_in = $signed({1'b0, x1_ff[31:0]}) * $signed({1'b0, p1});
      xhi_in = x1_ff[63:32] * {16'd0, p1};
      nlo_in = nv_ff[31:0] * esc_pkg::P_SCALE;
      nhi_in = nv_ff[63:32] * {20'd0, esc_pkg::P_SCALE};
      e48    = eh_ff * h2;
      f32    = e48[31:0] + esc_pkg::H_F_RND;
      fh_in  = $signed(f32) >>> 14;

      u64b   = 64'(xlo_ff) + {xhi_ff, 32'd0};
      den_in = u64b[63:33];
      num_in = {20'd0, nlo_ff} + {nhi_ff, 32'd0};
      x64    = ah_ff[10] * fh_ff;
      xa_in  = x64[31:0];
   end

   // stage 12: divider setup, humidity square
   always_comb begin
      logic signed [31:0] s32;
      logic signed [63:0] sq64;
      s32            = xa_ff >>> 15;
      sq64           = s32 * s32;
      div_in[0].rem  = '0;
      div_in[0].nq   = num_ff[63] ? (64'd0 - num_ff) : num_ff;
      div_in[0].dmag = den_ff[30] ? (31'd0 - den_ff) : den_ff;
      div_in[0].neg  = num_ff[63] ^ den_ff[30];
      div_in[0].inv  = (den_ff == '0);
      div_in[0].side = side_ff[11];
      div_in[0].hx_a = xa_ff;
      div_in[0].hx_b = sq64[31:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rt_ff    <= req_raw_temperature;
         rp_ff[1] <= req_raw_pressure;
         rh_ff[1] <= req_raw_humidity;
         for (int i = 2; i <= 8; i++) rp_ff[i] <= rp_ff[i-1];
         for (int i = 2; i <= 6; i++) rh_ff[i] <= rh_ff[i-1];
         ma_ff      <= ma_in;
         mb_ff      <= mb_in;
         v1t_ff     <= v1t_in;
         v2t_ff     <= v2t_in;
         tf_ff      <= tf_in;
         side_ff[5] <= side_in;
         for (int i = 6; i <= 11; i++) side_ff[i] <= side_ff[i-1];
         v1p_ff    <= v1p_in;
         xh_ff     <= xh_in;
         v1sq_ff   <= v1sq_in;
         pm5_ff    <= pm5_in;
         pm2_ff    <= pm2_in;
         h5x_ff    <= h5x_in;
         xh6_ff    <= xh6_in;
         xh3_ff    <= xh3_in;
         q6lo_ff   <= q6lo_in;
         q6hi_ff   <= q6hi_in;
         q3lo_ff   <= q3lo_in;
         q3hi_ff   <= q3hi_in;
         pm5b_ff   <= pm5_ff;
         pm2b_ff   <= pm2_ff;
         ah_ff[7]  <= ah_in;
         for (int i = 8; i <= 10; i++) ah_ff[i] <= ah_ff[i-1];
         ch_ff     <= ch_in;
         dh_ff     <= dh_in;
         v2_ff     <= v2_in;
         v1b_ff    <= v1b_in;
         cd_ff     <= cd_in;
         x1_ff     <= x1_in;
         nv_ff     <= nv_in;
         eh_ff     <= eh_in;
         xlo_ff    <= xlo_in;
         xhi_ff    <= xhi_in;
         nlo_ff    <= nlo_in;
         nhi_ff    <= nhi_in;
         fh_ff     <= fh_in;
         den_ff    <= den_in;
         num_ff    <= num_in;
         xa_ff     <= xa_in;
         div_ff[0] <= div_in[0];
      end
   end

   // ---------------- restoring divider, one quotient bit per stage ----------------
   for (genvar k = 1; k <= ND; k++) begin : g_div
      logic [31:0] rs;
      logic [31:0] diff;
      logic        ge;

      always_comb begin
         logic signed [31:0] u32;
         logic signed [40:0] hm41;
         rs        = {div_ff[k-1].rem, div_ff[k-1].nq[63]};
         diff      = rs - {1'b0, div_ff[k-1].dmag};
         ge        = (rs >= {1'b0, div_ff[k-1].dmag});
         div_in[k] = div_ff[k-1];
         div_in[k].rem = ge ? diff[30:0] : rs[30:0];
         div_in[k].nq  = {div_ff[k-1].nq[62:0], ge};
         u32  = $signed(div_ff[k-1].hx_b) >>> 7;
         hm41 = u32 * $signed({1'b0, h1});
         // humidity tail rides along the first divider stages
         if (k == 1)
            div_in[k].hx_b = hm41[31:0];
         else if (k == 2)
            div_in[k].hx_a = {15'd0, esc_pkg::hum_fin(div_ff[k-1].hx_a, div_ff[k-1].hx_b)};
      end

      always_ff @(posedge clock) begin
         if (en)
            div_ff[k] <= div_in[k];
      end
   end

   // ---------------- pressure finish ----------------
   always_comb begin
      logic [63:0] s64;
      logic [63:0] u1, u2, u3;
      logic [63:0] w64;
      qs_in      = div_ff[ND].neg ? (64'd0 - div_ff[ND].nq) : div_ff[ND].nq;
      pst_in.side = div_ff[ND].side;
      pst_in.hum  = div_ff[ND].hx_a[16:0];
      pst_in.inv  = div_ff[ND].inv;

      s64     = $signed(qs_ff[0]) >>> 13;
      sslo_in = {32'd0, s64[31:0]} * {32'd0, s64[31:0]};
      sshi_in = s64[31:0] * s64[63:32];
      b8lo_in = $signed({1'b0, qs_ff[0][31:0]}) * p8;
      b8hi_in = qs_ff[0][63:32] * {{16{p8[15]}}, p8};

      ss_in = sslo_ff + {sshi_ff[30:0], 33'd0};
      u1    = 64'(b8lo_ff) + {b8hi_ff, 32'd0};
      b8_in = $signed(u1) >>> 19;

      a9lo_in = $signed({1'b0, ss_ff[31:0]}) * p9;
      a9hi_in = ss_ff[63:32] * {{16{p9[15]}}, p9};

      u2    = 64'(a9lo_ff) + {a9hi_ff, 32'd0};
      a9_in = $signed(u2) >>> 25;

      u3      = qs_ff[4] + a9_ff + b8_ff[2];
      w64     = ($signed(u3) >>> 8) + (64'(p7) << 4);
      pres_in = pst_ff[4].inv ? 32'd0 : w64[31:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qs_ff[0]  <= qs_in;
         pst_ff[0] <= pst_in;
         for (int i = 1; i <= 4; i++) begin
            qs_ff[i]  <= qs_ff[i-1];
            pst_ff[i] <= pst_ff[i-1];
         end
         sslo_ff  <= sslo_in;
         sshi_ff  <= sshi_in;
         b8lo_ff  <= b8lo_in;
         b8hi_ff  <= b8hi_in;
         ss_ff    <= ss_in;
         b8_ff[0] <= b8_in;
         b8_ff[1] <= b8_ff[0];
         b8_ff[2] <= b8_ff[1];
         a9lo_ff  <= a9lo_in;
         a9hi_ff  <= a9hi_in;
         a9_ff    <= a9_in;
         temp_o_ff <= pst_ff[4].side.temp;
         tf_o_ff   <= pst_ff[4].side.tf;
         pres_o_ff <= pres_in;
         inv_o_ff  <= pst_ff[4].inv;
         hum_o_ff  <= pst_ff[4].hum;
      end
   end

   assign rsp_valid            = vld_ff[NS-1];
   assign rsp_temperature      = temp_o_ff;
   assign rsp_fine_temperature = tf_o_ff;
   assign rsp_pressure         = pres_o_ff;
   assign rsp_pressure_invalid = inv_o_ff;
   assign rsp_humidity         = hum_o_ff;

   // ---------------- assertions ----------------
   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pressure_invalid |-> rsp_pressure == 32'd0)
      else $error("pressure not cleared on zero divisor");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_humidity <= 17'd102400)
      else $error("humidity above clamp");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |=> rsp_valid == $past(vld_ff[NS-2]))
      else $error("valid bit lost or duplicated at output");

   a_div_flag: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS-POST_OFS] && div_ff[ND].inv |-> div_ff[ND].dmag == '0)
      else $error("zero divisor flag mismatch");

endmodule
